FILE: rtl/clock_sweep_page_buffer_macros.svh
// Assertion macros for the clock sweep page buffer.
// Expects clk and arst_n in scope at the point of use.
`ifndef CLOCK_SWEEP_PAGE_BUFFER_MACROS_SVH
`define CLOCK_SWEEP_PAGE_BUFFER_MACROS_SVH

// same-cycle implication
`define CSPB_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clock sweep page buffer: check failed");

// next-cycle implication
`define CSPB_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clock sweep page buffer: check failed");

`endif

FILE: rtl/cspb_pkg.sv
// Shared types and constants for the clock sweep page buffer.
// No dependencies; used by cspb_ctrl, cspb_datapath and the top level.
package cspb_pkg;

	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic ACT_ACCESS = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	localparam logic [2:0] OUT_HIT     = 3'd0;
	localparam logic [2:0] OUT_MISS    = 3'd1;
	localparam logic [2:0] OUT_UPDATED = 3'd2;
	localparam logic [2:0] OUT_FILLED  = 3'd3;
	localparam logic [2:0] OUT_EVICTED = 3'd4;

	typedef struct packed {
		logic        action;
		logic [31:0] page_key;
		logic [31:0] page_value;
	} in_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [2:0]  frame_index;
		logic [31:0] read_value;
		logic [31:0] evicted_key;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic fin_hit;
		logic fin_miss;
		logic fin_fill;
		logic sweep;
		logic evict;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic match;
		logic last;
		logic empty_any;
		logic insert;
		logic ref_set;
	} sts_t;

endpackage

FILE: rtl/cspb_ctrl.sv
// Controller state machine for the clock sweep page buffer.
// Depends on cspb_pkg (cmd_t, sts_t).
module cspb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  cspb_pkg::sts_t sts,
	output cspb_pkg::cmd_t cmd,
	output logic           busy
);
	import cspb_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SWEEP = 2'd2;
	localparam logic [1:0] S_EVICT = 2'd3;

	logic [1:0] state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.match) begin
					cmd.fin_hit = 1'b1;
					state_d     = S_IDLE;
				end else if (sts.last) begin
					if (!sts.insert) begin
						cmd.fin_miss = 1'b1;
						state_d      = S_IDLE;
					end else if (sts.empty_any) begin
						cmd.fin_fill = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_SWEEP;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				// victim found: its key read is in flight
				if (!sts.ref_set) begin
					state_d = S_EVICT;
				end
			end
			S_EVICT: begin
				cmd.evict = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: rtl/cspb_datapath.sv
// Datapath for the clock sweep page buffer: key/value memories, valid and
// reference bits, clock hand, scan pipeline and result register. Uses cspb_pkg.
module cspb_datapath #(
	parameter int FRAMES      = 8,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cspb_pkg::CFG_W-1:0]   cfg_data,
	input  cspb_pkg::in_t                request,
	input  cspb_pkg::cmd_t               cmd,
	output cspb_pkg::sts_t               sts,
	output logic                         done,
	output cspb_pkg::out_t               result
);
	import cspb_pkg::*;

	localparam int IW = $clog2(FRAMES);
	localparam int NW = $clog2(FRAMES + 1);

	logic [KEY_WIDTH-1:0]   key_mem   [FRAMES];
	logic [VALUE_WIDTH-1:0] value_mem [FRAMES];

	logic [KEY_WIDTH-1:0]   key_rd_s1;
	logic [VALUE_WIDTH-1:0] val_rd_s1;
	logic                   rd_vld_s1;
	logic [IW-1:0]          cmp_idx_s1;

	logic                   action_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [NW-1:0]          n_q;
	logic [NW-1:0]          scan_idx_q;
	logic [IW-1:0]          sweep_idx_q;
	logic [IW-1:0]          hand_q;
	logic [FRAMES-1:0]      valid_q;
	logic [FRAMES-1:0]      ref_q;
	logic                   empty_found_q;
	logic [IW-1:0]          empty_idx_q;
	logic [CFG_W-1:0]       cfg_q;
	logic                   done_q;
	out_t                   result_q;

	logic [NW-1:0]          n_cfg;
	logic [IW-1:0]          rd_addr;
	logic [IW-1:0]          wr_addr;
	logic                   wr_key;
	logic                   wr_val;
	logic                   issue;
	logic                   match;
	logic                   cmp_empty;
	logic                   empty_any;
	logic [IW-1:0]          empty_sel;
	logic [IW-1:0]          sweep_next;
	logic                   fin_any;
	out_t                   result_d;

	// active frame count: zero acts as one, above FRAMES clamps
	always_comb begin
		if (cfg_q == '0) begin
			n_cfg = NW'(1);
		end else if (32'(cfg_q) > 32'(FRAMES)) begin
			n_cfg = NW'(FRAMES);
		end else begin
			n_cfg = NW'(cfg_q);
		end
	end

	assign rd_addr   = cmd.scan ? scan_idx_q[IW-1:0] : sweep_idx_q;
	assign issue     = cmd.scan && (scan_idx_q < n_q);
	assign match     = rd_vld_s1 && valid_q[cmp_idx_s1] && (key_rd_s1 == key_q);
	assign cmp_empty = rd_vld_s1 && !valid_q[cmp_idx_s1];
	assign empty_any = empty_found_q || cmp_empty;
	assign empty_sel = empty_found_q ? empty_idx_q : cmp_idx_s1;
	assign sweep_next = ((NW'(sweep_idx_q) + NW'(1)) == n_q) ? '0 : sweep_idx_q + IW'(1);
	assign fin_any   = cmd.fin_hit || cmd.fin_miss || cmd.fin_fill || cmd.evict;

	assign wr_key  = cmd.fin_fill || cmd.evict;
	assign wr_val  = wr_key || (cmd.fin_hit && (action_q == ACT_INSERT));
	assign wr_addr = cmd.fin_fill ? empty_sel : (cmd.evict ? sweep_idx_q : cmp_idx_s1);

	always_comb begin
		sts.match     = match;
		sts.last      = rd_vld_s1 && ((NW'(cmp_idx_s1) + NW'(1)) == n_q);
		sts.empty_any = empty_any;
		sts.insert    = (action_q == ACT_INSERT);
		sts.ref_set   = ref_q[sweep_idx_q];
	end

	// key and value memories, registered read
	always_ff @(posedge clk) begin
		key_rd_s1 <= key_mem[rd_addr];
		val_rd_s1 <= value_mem[rd_addr];
		if (wr_key) begin
			key_mem[wr_addr] <= key_q;
		end
		if (wr_val) begin
			value_mem[wr_addr] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q         <= CFG_RESET;
			valid_q       <= '0;
			ref_q         <= '0;
			hand_q        <= '0;
			done_q        <= 1'b0;
			rd_vld_s1     <= 1'b0;
			n_q           <= NW'(FRAMES);
			scan_idx_q    <= '0;
			sweep_idx_q   <= '0;
			empty_found_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			done_q    <= fin_any;
			rd_vld_s1 <= issue;

			if (cmd.load) begin
				n_q           <= n_cfg;
				scan_idx_q    <= '0;
				empty_found_q <= 1'b0;
				// hand outside the active range restarts at frame 0
				sweep_idx_q   <= (NW'(hand_q) >= n_cfg) ? '0 : hand_q;
			end else begin
				if (issue) begin
					scan_idx_q <= scan_idx_q + NW'(1);
				end
				if (cmd.scan && cmp_empty && !empty_found_q) begin
					empty_found_q <= 1'b1;
				end
			end

			if (cmd.fin_hit) begin
				ref_q[cmp_idx_s1] <= 1'b1;
			end
			if (cmd.fin_fill) begin
				valid_q[empty_sel] <= 1'b1;
				ref_q[empty_sel]   <= 1'b1;
			end
			// second chance: clear and move on
			if (cmd.sweep && ref_q[sweep_idx_q]) begin
				ref_q[sweep_idx_q] <= 1'b0;
				sweep_idx_q        <= sweep_next;
			end
			if (cmd.evict) begin
				valid_q[sweep_idx_q] <= 1'b1;
				ref_q[sweep_idx_q]   <= 1'b1;
				hand_q               <= sweep_next;
			end
		end
	end

	always_comb begin
		result_d = '0;
		if (cmd.fin_hit) begin
			result_d.frame_index = 3'(cmp_idx_s1);
			if (action_q == ACT_INSERT) begin
				result_d.outcome = OUT_UPDATED;
			end else begin
				result_d.outcome    = OUT_HIT;
				result_d.read_value = 32'(val_rd_s1);
			end
		end else if (cmd.fin_miss) begin
			result_d.outcome = OUT_MISS;
		end else if (cmd.fin_fill) begin
			result_d.outcome     = OUT_FILLED;
			result_d.frame_index = 3'(empty_sel);
		end else if (cmd.evict) begin
			result_d.outcome     = OUT_EVICTED;
			result_d.frame_index = 3'(sweep_idx_q);
			result_d.evicted_key = 32'(key_rd_s1);
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_idx_q[IW-1:0];
		if (cmd.load) begin
			action_q <= request.action;
			key_q    <= KEY_WIDTH'(request.page_key);
			val_q    <= VALUE_WIDTH'(request.page_value);
		end
		if (cmd.scan && cmp_empty && !empty_found_q) begin
			empty_idx_q <= cmp_idx_s1;
		end
		if (fin_any) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/clock_sweep_page_buffer.sv
// Clock sweep page buffer top level: controller plus datapath.
// Depends on cspb_pkg, cspb_ctrl, cspb_datapath and the assertion macro header.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------
//   request  | start, busy         | request (in_t)
//   result   | done (1-cycle)      | result (out_t)
//   config   | cfg_we              | cfg_data (frames_in_use)
//
// A hit ends the scan at the matching frame; a miss, or an insert that fills an
// empty frame, ends once the last active frame is compared; an eviction follows
// the full scan with a hand sweep. The key memory is scanned one frame per cycle
// through its one read port, and the hand visits one reference bit per cycle.
// Reset clears valid bits, reference bits and the hand at once; no clearing pass.
// busy is high from acceptance until the cycle the result strobe shows.
`include "clock_sweep_page_buffer_macros.svh"

module clock_sweep_page_buffer #(
	parameter int FRAMES      = 8,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cspb_pkg::CFG_W-1:0] cfg_data,
	input  logic                       start,
	input  cspb_pkg::in_t              request,
	output logic                       busy,
	output logic                       done,
	output cspb_pkg::out_t             result
);
	import cspb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cspb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	cspb_datapath #(
		.FRAMES      (FRAMES),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.request  (request),
		.cmd      (cmd),
		.sts      (sts),
		.done     (done),
		.result   (result)
	);

	`CSPB_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`CSPB_ASSERT_IMP(a_done_idle, done, !busy)
	`CSPB_ASSERT_IMP(a_evkey_zero, done && (result.outcome != OUT_EVICTED), result.evicted_key == '0)
	`CSPB_ASSERT_IMP(a_miss_zero, done && (result.outcome == OUT_MISS), (result.frame_index == '0) && (result.read_value == '0))

endmodule

FILE: tb/clock_sweep_page_buffer_tb.sv
// Self-checking testbench for clock_sweep_page_buffer (clock replacement page buffer).
// Depends on cspb_pkg and the RTL; an in-bench predictor scores every result strobe.
module clock_sweep_page_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cspb_pkg::*;

	localparam int FRAMES = 8;
	localparam int SETTLE_CYCLES = 2 * FRAMES + 8;

	// Predicts outcomes of the page buffer and scores the results against them.
	class page_buffer_scoreboard;
		logic [31:0] keys[FRAMES];
		logic [31:0] vals[FRAMES];
		bit valid[FRAMES];
		bit refbit[FRAMES];
		int hand;
		logic [CFG_W-1:0] frames_cfg;
		out_t awaited[$];
		int failures;
		int requests;
		int outcome_count[5];

		function new();
			for (int i = 0; i < FRAMES; i++) begin
				keys[i] = '0;
				vals[i] = '0;
				valid[i] = 1'b0;
				refbit[i] = 1'b0;
			end
			hand = 0;
			frames_cfg = CFG_RESET;
			failures = 0;
			requests = 0;
			for (int i = 0; i < 5; i++)
				outcome_count[i] = 0;
		endfunction

		function void set_frames(logic [CFG_W-1:0] v);
			frames_cfg = v;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function out_t lookup_or_place(in_t r);
			out_t o;
			int n;
			int hit;
			int slot;
			int h;
			o = '0;
			o.outcome = OUT_MISS;
			n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
			hit = -1;
			for (int i = 0; i < n; i++)
				if (hit < 0 && valid[i] && keys[i] == r.page_key)
					hit = i;
			if (r.action == ACT_ACCESS) begin
				if (hit >= 0) begin
					refbit[hit] = 1'b1;
					o.outcome = OUT_HIT;
					o.frame_index = hit[2:0];
					o.read_value = vals[hit];
				end
			end else if (hit >= 0) begin
				vals[hit] = r.page_value;
				refbit[hit] = 1'b1;
				o.outcome = OUT_UPDATED;
				o.frame_index = hit[2:0];
			end else begin
				slot = -1;
				for (int i = 0; i < n; i++)
					if (slot < 0 && !valid[i])
						slot = i;
				if (slot < 0) begin
					h = (hand >= n) ? 0 : hand;
					// first pass clears every set bit, so this ends within two laps
					while (refbit[h]) begin
						refbit[h] = 1'b0;
						h = (h + 1) % n;
					end
					o.evicted_key = keys[h];
					o.outcome = OUT_EVICTED;
					slot = h;
					hand = (h + 1) % n;
				end else begin
					o.outcome = OUT_FILLED;
				end
				keys[slot] = r.page_key;
				vals[slot] = r.page_value;
				valid[slot] = 1'b1;
				refbit[slot] = 1'b1;
				o.frame_index = slot[2:0];
			end
			return o;
		endfunction

		function void note_request(in_t r);
			awaited.push_back(lookup_or_place(r));
			requests++;
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (awaited.size() == 0) begin
				$error("result strobe with no request outstanding: outcome %0d", got.outcome);
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (want.outcome < 5)
				outcome_count[want.outcome]++;
			if (got.outcome !== want.outcome) begin
				$error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
				failures++;
			end
			if (got.frame_index !== want.frame_index) begin
				$error("frame_index: expected %0d, got %0d", want.frame_index, got.frame_index);
				failures++;
			end
			if (got.read_value !== want.read_value) begin
				$error("read_value: expected %h, got %h", want.read_value, got.read_value);
				failures++;
			end
			if (got.evicted_key !== want.evicted_key) begin
				$error("evicted_key: expected %h, got %h", want.evicted_key, got.evicted_key);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_data = CFG_RESET;
	logic start = 1'b0;
	in_t request = '0;
	logic busy;
	logic done;
	out_t result;

	page_buffer_scoreboard sb = new();
	logic [31:0] key_pool[16];
	bit no_idle = 1'b0;
	int settings_used = 0;
	int pauses = 0;

	clock_sweep_page_buffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	initial begin
		#4ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// one request through the start/busy handshake, then an optional random idle stretch
	task automatic issue(logic act, logic [31:0] key, logic [31:0] val);
		in_t r;
		int gap;
		r.action = act;
		r.page_key = key;
		r.page_value = val;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		int guard;
		start <= 1'b0;
		for (guard = 0; guard < 4000 && sb.pending() > 0; guard++)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_frames(logic [CFG_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		sb.set_frames(v);
		settings_used++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_key(int pool_size);
		int r;
		r = $urandom_range(0, 99);
		if (r < 82)
			return key_pool[$urandom_range(0, pool_size - 1)];
		if (r < 90)
			return $urandom;
		if (r < 95)
			return 32'h0000_0000;
		return 32'hFFFF_FFFF;
	endfunction

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 32'h0000_0000;
		if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	initial begin
		logic [CFG_W-1:0] phase_frames[12];
		int pool_size;
		phase_frames = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd6,
			4'd9, 4'd2, 4'd5, 4'd12, 4'd4, 4'd7};
		for (int i = 0; i < 16; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fills, hits, update, full two-lap sweep, count of zero, duplicates
		issue(ACT_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF);
		issue(ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
		issue(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(ACT_ACCESS, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(ACT_ACCESS, 32'h0000_0000, 32'h1234_5678);
		issue(ACT_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
		for (int i = 2; i < FRAMES; i++)
			issue(ACT_INSERT, 32'h1000_0000 + i, 32'h2000_0000 + i);
		issue(ACT_INSERT, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
		issue(ACT_ACCESS, 32'h0000_0000, 32'h0000_0000);
		issue(ACT_ACCESS, 32'h5A5A_5A5A, 32'h0000_0000);
		issue(ACT_INSERT, 32'h1234_5678, 32'h8765_4321);
		// zero acts as one frame; the hand now sits beyond the count
		write_frames(4'd0);
		issue(ACT_ACCESS, 32'h5A5A_5A5A, 32'h0000_0000);
		issue(ACT_INSERT, 32'hDEAD_BEEF, 32'hCAFE_F00D);
		issue(ACT_INSERT, 32'h1000_0003, 32'h3333_3333);
		// above the frame count acts as all frames; frames 0 and 3 share a key
		write_frames(4'd15);
		issue(ACT_ACCESS, 32'h1000_0003, 32'h0000_0000);
		issue(ACT_INSERT, 32'h1000_0003, 32'h0000_0000);
		issue(ACT_ACCESS, 32'h1000_0007, 32'h0000_0000);

		for (int p = 0; p < 12; p++) begin
			write_frames(phase_frames[p]);
			no_idle = (p % 3 == 1);
			pool_size = $urandom_range(2, 16);
			for (int k = 0; k < 128; k++) begin
				if ($urandom_range(0, 63) == 0) begin
					drain();
					pauses++;
				end
				issue(($urandom_range(0, 99) < 55) ? ACT_INSERT : ACT_ACCESS,
					pick_key(pool_size), pick_value());
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() > 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.failures++;
		end
		$display("Ran %0d requests under %0d frame-count writes, %0d full pauses.",
			sb.requests, settings_used, pauses);
		$display("Outcomes: hit %0d, miss %0d, update %0d, fill %0d, evict %0d.",
			sb.outcome_count[OUT_HIT], sb.outcome_count[OUT_MISS],
			sb.outcome_count[OUT_UPDATED], sb.outcome_count[OUT_FILLED],
			sb.outcome_count[OUT_EVICTED]);
		if (sb.failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl
rtl/cspb_pkg.sv
rtl/cspb_ctrl.sv
rtl/cspb_datapath.sv
rtl/clock_sweep_page_buffer.sv
tb/clock_sweep_page_buffer_tb.sv
